// File: rtl/tgsam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone generator package
// Shared types, register indexes, fixed field widths and the helper functions
// that build the quarter-wave sine table and scale signed values.
// ----------------------------------------------------------------------------
package tgsam_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARRIER_STEP = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_STEP     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AM_DEPTH     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FM_INDEX     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_COUNT = 3'd6;

   // Fixed field widths.
   localparam int SAMPLE_BITS   = 16;
   localparam int TABLE_BITS    = 15;
   localparam int AMP_BITS      = 20;
   localparam int STEP_BITS     = 32;
   localparam int FM_INDEX_BITS = 24;
   localparam int COUNT_BITS    = 24;

   // Datapath widths of the shared multiplier and the scaling chain.
   localparam int MUL_A_BITS  = 25;
   localparam int MUL_B_BITS  = 21;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int ENV_BITS    = 21;
   localparam int GAIN_BITS   = 25;
   localparam int SCALED_BITS = 62;

   localparam logic signed [AMP_BITS-1:0] AMP_RESET = 20'sd65536;

   // Operating modes.
   typedef enum logic [1:0] {
      MODE_SINE   = 2'd0,
      MODE_AM     = 2'd1,
      MODE_FM     = 2'd2,
      MODE_SILENT = 2'd3
   } mode_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      mode_type                         mode;
      logic signed [AMP_BITS-1:0]       amplitude;
      logic [STEP_BITS-1:0]             carrier_step;
      logic [STEP_BITS-1:0]             mod_step;
      logic signed [AMP_BITS-1:0]       am_depth;
      logic [FM_INDEX_BITS-1:0]         fm_index;
      logic [COUNT_BITS-1:0]            sample_count;
   } cfg_type;

   // Fill status of the queue between front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      B_IDLE,
      B_CAR,
      B_MOD,
      B_ENV,
      B_GAIN,
      B_GTRUNC,
      B_FINAL,
      B_OFS,
      B_FMUL,
      B_SCALE,
      B_SAT,
      B_DONE
   } back_state_type;

   // Quarter of pi in Q2.30 times two, halved: pi/2 in Q2.30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Divisors of the odd Taylor terms: (2n)(2n+1) for n = 1 to 9.
   localparam logic [63:0] TAYLOR_DIV [9] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
   };

   // Entry k of the quarter-wave table in unsigned Q0.15, evaluated at elaboration.
   function automatic logic [TABLE_BITS-1:0] quarter_sine(input int unsigned k,
                                                          input int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x    = (HALF_PI_Q30 * 64'(k)) >> bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n < 10; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if ((n & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 64'sd0) begin
         sum = 64'sd0;
      end
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return v[TABLE_BITS-1:0];
   endfunction

   // Arithmetic right shift that rounds toward zero, as a signed division.
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] value,
                                                    input int unsigned shift);
      logic signed [63:0] bias;
      bias = value[63] ? ((64'sd1 <<< shift) - 64'sd1) : 64'sd0;
      return (value + bias) >>> shift;
   endfunction

endpackage

// File: rtl/tone_generator_sine_am_fm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine, AM and FM tone generator
// Direct digital synthesis tone source: one input word is one sample tick,
// and each tick in a run yields one signed 16-bit sample word unless the mode is silent.
// ----------------------------------------------------------------------------
// A tick word is taken whenever the two-word queue between the front end and
// the sample sequencer has room; ticks that give no sample (idle, silent
// mode, count reached) finish as they are taken. Each sample then passes
// through the fewest sequencer states in sine mode, more in FM mode and the
// most in AM mode, set by the single shared multiplier and the single
// registered port of the sine table, plus the time the word waits at the output.
// Registers must be written through csr_we, csr_index and csr_wdata only while
// the block is idle; the block itself does not enforce this.
module tone_generator_sine_am_fm
   import tgsam_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration write port.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // Tick words.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] restart, [7:1] zero
   // Sample words.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [15:0] sample
   output logic                      rsp_tlast,   // last sample of the run
   output logic [0:0]                rsp_tuser    // [0] clipped
);

   localparam int ITEM_BITS = 2 * PHASE_BITS + 3;

   cfg_type                       cfg;
   q_status_type                  q_status;
   logic                          q_push;
   logic                          q_pop;
   logic [ITEM_BITS-1:0]          q_wdata;
   logic [ITEM_BITS-1:0]          q_rdata;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          clipped;

   // Tick classification and run state.
   tgsam_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_wdata     (q_wdata),
      .cfg         (cfg)
   );

   // Queue between front end and sequencer.
   tgsam_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (2)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Sample sequencer and output word.
   tgsam_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_status    (q_status),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (sample),
      .rsp_last    (rsp_tlast),
      .rsp_clipped (clipped)
   );

   assign rsp_tdata    = sample;
   assign rsp_tuser[0] = clipped;

   // A word is queued only when the queue has room.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("tick word queued into a full queue");

   // The sequencer takes a word only when one is there.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("sequencer popped an empty queue");

   // Only an accepted tick can queue a sample.
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready))
      else $error("sample queued without an accepted tick");

   // No sample word is offered straight after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("sample word valid straight after reset");

endmodule

// File: rtl/tgsam_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone generator word queue
// Small first-in first-out buffer that decouples the tick front end from the
// sample back end.
// ----------------------------------------------------------------------------
module tgsam_queue
   import tgsam_pkg::*;
#(
   parameter int WIDTH = 67,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output q_status_type     status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/tgsam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone generator front end
// Holds the configuration registers and the run state, accepts ticks,
// decides whether each tick yields a sample and queues the phases for it.
// ----------------------------------------------------------------------------
module tgsam_front
   import tgsam_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_restart,
   input  q_status_type                   q_status,
   output logic                           q_push,
   output logic [2*PHASE_BITS+2:0]        q_wdata,
   output cfg_type                        cfg
);

   cfg_type                 cfg_ff, cfg_in;
   logic [PHASE_BITS-1:0]   carrier_ff, carrier_in;
   logic [PHASE_BITS-1:0]   modph_ff, modph_in;
   logic [COUNT_BITS-1:0]   index_ff, index_in;
   logic                    running_ff, running_in;

   logic                    accept;
   logic                    run_now;
   logic [PHASE_BITS-1:0]   carrier_now;
   logic [PHASE_BITS-1:0]   modph_now;
   logic [COUNT_BITS-1:0]   index_now;
   logic [COUNT_BITS-1:0]   index_next;
   logic                    in_range;
   logic                    last;
   logic                    emit;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:         cfg_in.mode         = mode_type'(csr_wdata[1:0]);
            CSR_AMPLITUDE:    cfg_in.amplitude    = $signed(csr_wdata[AMP_BITS-1:0]);
            CSR_CARRIER_STEP: cfg_in.carrier_step = csr_wdata[STEP_BITS-1:0];
            CSR_MOD_STEP:     cfg_in.mod_step     = csr_wdata[STEP_BITS-1:0];
            CSR_AM_DEPTH:     cfg_in.am_depth     = $signed(csr_wdata[AMP_BITS-1:0]);
            CSR_FM_INDEX:     cfg_in.fm_index     = csr_wdata[FM_INDEX_BITS-1:0];
            CSR_SAMPLE_COUNT: cfg_in.sample_count = csr_wdata[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Classify the tick: restart first, then the count check, then the mode.
   assign accept      = req_tvalid && !q_status.full;
   assign run_now     = req_restart || running_ff;
   assign carrier_now = req_restart ? '0 : carrier_ff;
   assign modph_now   = req_restart ? '0 : modph_ff;
   assign index_now   = req_restart ? '0 : index_ff;
   assign index_next  = index_now + 1'b1;
   assign in_range    = (index_now < cfg_ff.sample_count);
   assign last        = (index_next == cfg_ff.sample_count);
   assign emit        = accept && run_now && in_range && (cfg_ff.mode != MODE_SILENT);

   // Run state advance.
   always_comb begin
      carrier_in = carrier_ff;
      modph_in   = modph_ff;
      index_in   = index_ff;
      running_in = running_ff;
      if (accept) begin
         carrier_in = carrier_now;
         modph_in   = modph_now;
         index_in   = index_now;
         running_in = run_now;
         if (run_now && !in_range) begin
            running_in = 1'b0;
         end else if (emit) begin
            carrier_in = carrier_now + cfg_ff.carrier_step[PHASE_BITS-1:0];
            modph_in   = modph_now + cfg_ff.mod_step[PHASE_BITS-1:0];
            index_in   = index_next;
            if (last) begin
               running_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_SINE;
         cfg_ff.amplitude    <= AMP_RESET;
         cfg_ff.carrier_step <= '0;
         cfg_ff.mod_step     <= '0;
         cfg_ff.am_depth     <= '0;
         cfg_ff.fm_index     <= '0;
         cfg_ff.sample_count <= '0;
         carrier_ff          <= '0;
         modph_ff            <= '0;
         index_ff            <= '0;
         running_ff          <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         carrier_ff <= carrier_in;
         modph_ff   <= modph_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   // Queue word: carrier phase lowest, then modulator phase, last flag, mode.
   assign q_push     = emit;
   assign q_wdata    = {cfg_ff.mode, last, modph_now, carrier_now};
   assign req_tready = !q_status.full;
   assign cfg        = cfg_ff;

endmodule

// File: rtl/tgsam_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone generator sine lookup
// Quarter-wave table with a registered read; folds the phase into the table
// address and restores the sign after the registered read.
// ----------------------------------------------------------------------------
module tgsam_sine
   import tgsam_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  logic                          clock,
   input  logic [PHASE_BITS-1:0]         phase,
   output logic signed [SAMPLE_BITS-1:0] sine
);

   localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
   localparam int ADDR_BITS = SINE_TABLE_BITS + 1;
   localparam int TOP_BITS  = SINE_TABLE_BITS + 2;

   logic [TABLE_BITS-1:0]      sine_table [TABLE_LEN];
   logic [TOP_BITS-1:0]        top;
   logic [1:0]                 quad;
   logic [ADDR_BITS-1:0]       addr;
   logic [TABLE_BITS-1:0]      rom_ff, rom_in;
   logic                       neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0] mag;

   // Constant table, one entry per address.
   for (genvar k = 0; k < TABLE_LEN; k++) begin : g_entry
      localparam logic [TABLE_BITS-1:0] ENTRY = quarter_sine(k, SINE_TABLE_BITS);
      assign sine_table[k] = ENTRY;
   end

   // Quadrant fold: odd quadrants read the table mirrored.
   assign top  = phase[PHASE_BITS-1 -: TOP_BITS];
   assign quad = top[TOP_BITS-1 -: 2];
   assign addr = quad[0] ? (ADDR_BITS'(TABLE_LEN - 1) - {1'b0, top[SINE_TABLE_BITS-1:0]})
                         : {1'b0, top[SINE_TABLE_BITS-1:0]};

   assign rom_in = sine_table[addr];
   assign neg_in = quad[1];

   always_ff @(posedge clock) begin
      rom_ff <= rom_in;
      neg_ff <= neg_in;
   end

   // The upper half of the wave is negated.
   assign mag  = $signed({1'b0, rom_ff});
   assign sine = neg_ff ? -mag : mag;

endmodule

// File: rtl/tgsam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone generator back end
// Sequencer that takes queued phases, reads the sine table, runs the AM or
// FM arithmetic on one shared multiplier and holds the result word.
// ----------------------------------------------------------------------------
module tgsam_back
   import tgsam_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  q_status_type                  q_status,
   input  logic [2*PHASE_BITS+2:0]       q_rdata,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last,
   output logic                          rsp_clipped
);

   localparam int FM_SHIFT = 32 - PHASE_BITS;

   back_state_type state_ff, state_in;

   // Current item.
   logic [PHASE_BITS-1:0]          cur_carrier_ff, cur_carrier_in;
   logic [PHASE_BITS-1:0]          cur_modph_ff, cur_modph_in;
   logic                           cur_last_ff, cur_last_in;
   mode_type                       cur_mode_ff, cur_mode_in;

   // Arithmetic registers.
   logic signed [SAMPLE_BITS-1:0]  sc_ff, sc_in;
   logic signed [ENV_BITS-1:0]     env_ff, env_in;
   logic signed [GAIN_BITS-1:0]    gain_ff, gain_in;
   logic signed [PROD_BITS-1:0]    prod_ff, prod_in;
   logic signed [SCALED_BITS-1:0]  scaled_ff, scaled_in;
   logic signed [SAMPLE_BITS-1:0]  res_ff, res_in;
   logic                           res_clip_ff, res_clip_in;

   // Result word.
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0]  out_sample_ff, out_sample_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_clip_ff, out_clip_in;

   logic                           out_free;
   logic                           out_load;
   logic [PHASE_BITS-1:0]          sine_phase;
   logic signed [SAMPLE_BITS-1:0]  sine_value;
   logic signed [MUL_A_BITS-1:0]   mul_a;
   logic signed [MUL_B_BITS-1:0]   mul_b;
   logic signed [63:0]             prod_wide;
   logic signed [63:0]             scaled_wide;
   logic signed [63:0]             env_wide;
   logic signed [63:0]             gain_wide;
   logic signed [63:0]             off_wide;
   logic signed [63:0]             val_wide;
   logic [PHASE_BITS-1:0]          fm_phase;

   assign out_free = !out_valid_ff || rsp_tready;

   // Shared table port.
   tgsam_sine #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_sine (
      .clock (clock),
      .phase (sine_phase),
      .sine  (sine_value)
   );

   // Wide views of the product and scaled registers.
   assign prod_wide   = $signed({{(64 - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff});
   assign scaled_wide = $signed({{(64 - SCALED_BITS){scaled_ff[SCALED_BITS-1]}}, scaled_ff});
   assign env_wide    = 64'sd65536 + trunc_shr(prod_wide, 15);
   assign gain_wide   = trunc_shr(prod_wide, 16);
   assign off_wide    = trunc_shr(prod_wide <<< 1, FM_SHIFT);
   assign val_wide    = trunc_shr(scaled_wide, 31);
   assign fm_phase    = cur_carrier_ff + off_wide[PHASE_BITS-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               state_in = B_CAR;
            end
         end
         B_CAR: begin
            state_in = (cur_mode_ff == MODE_SINE) ? B_DONE : B_MOD;
         end
         B_MOD: begin
            state_in = (cur_mode_ff == MODE_AM) ? B_ENV : B_OFS;
         end
         B_ENV:    state_in = B_GAIN;
         B_GAIN:   state_in = B_GTRUNC;
         B_GTRUNC: state_in = B_FINAL;
         B_FINAL:  state_in = B_SCALE;
         B_OFS:    state_in = B_FMUL;
         B_FMUL:   state_in = B_SCALE;
         B_SCALE:  state_in = B_SAT;
         B_SAT:    state_in = B_DONE;
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default:  state_in = B_IDLE;
      endcase
   end

   // Sequencer outputs: queue pop, table address, multiplier operands and result load.
   always_comb begin
      q_pop      = 1'b0;
      out_load   = 1'b0;
      sine_phase = cur_carrier_ff;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         B_IDLE: begin
            q_pop      = !q_status.empty;
            sine_phase = q_rdata[PHASE_BITS-1:0];
         end
         B_CAR: begin
            sine_phase = cur_modph_ff;
         end
         B_MOD: begin
            if (cur_mode_ff == MODE_AM) begin
               mul_a = MUL_A_BITS'(cfg.am_depth);
            end else begin
               mul_a = $signed({1'b0, cfg.fm_index});
            end
            mul_b = MUL_B_BITS'(sine_value);
         end
         B_GAIN: begin
            mul_a = MUL_A_BITS'(cfg.amplitude);
            mul_b = env_ff;
         end
         B_FINAL: begin
            mul_a = gain_ff;
            mul_b = MUL_B_BITS'(sc_ff);
         end
         B_OFS: begin
            sine_phase = fm_phase;
         end
         B_FMUL: begin
            mul_a = MUL_A_BITS'(cfg.amplitude);
            mul_b = MUL_B_BITS'(sine_value);
         end
         B_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      cur_carrier_in = cur_carrier_ff;
      cur_modph_in   = cur_modph_ff;
      cur_last_in    = cur_last_ff;
      cur_mode_in    = cur_mode_ff;
      sc_in          = sc_ff;
      env_in         = env_ff;
      gain_in        = gain_ff;
      prod_in        = mul_a * mul_b;
      scaled_in      = scaled_ff;
      res_in         = res_ff;
      res_clip_in    = res_clip_ff;
      case (state_ff)
         B_IDLE: begin
            cur_carrier_in = q_rdata[PHASE_BITS-1:0];
            cur_modph_in   = q_rdata[2*PHASE_BITS-1:PHASE_BITS];
            cur_last_in    = q_rdata[2*PHASE_BITS];
            cur_mode_in    = mode_type'(q_rdata[2*PHASE_BITS+2:2*PHASE_BITS+1]);
         end
         B_CAR: begin
            sc_in       = sine_value;
            res_in      = sine_value;
            res_clip_in = 1'b0;
         end
         B_ENV: begin
            env_in = env_wide[ENV_BITS-1:0];
         end
         B_GTRUNC: begin
            gain_in = gain_wide[GAIN_BITS-1:0];
         end
         B_SCALE: begin
            // Times 32767 as a shift and subtract.
            scaled_in = SCALED_BITS'((prod_wide <<< 15) - prod_wide);
         end
         B_SAT: begin
            if (val_wide > 64'sd32767) begin
               res_in      = 16'sh7fff;
               res_clip_in = 1'b1;
            end else if (val_wide < -64'sd32768) begin
               res_in      = 16'sh8000;
               res_clip_in = 1'b1;
            end else begin
               res_in      = val_wide[SAMPLE_BITS-1:0];
               res_clip_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result word handover.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      out_clip_in   = out_clip_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_sample_in = res_ff;
         out_last_in   = cur_last_ff;
         out_clip_in   = res_clip_ff;
      end else if (rsp_tready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_carrier_ff <= cur_carrier_in;
      cur_modph_ff   <= cur_modph_in;
      cur_last_ff    <= cur_last_in;
      cur_mode_ff    <= cur_mode_in;
      sc_ff          <= sc_in;
      env_ff         <= env_in;
      gain_ff        <= gain_in;
      prod_ff        <= prod_in;
      scaled_ff      <= scaled_in;
      res_ff         <= res_in;
      res_clip_ff    <= res_clip_in;
      out_sample_ff  <= out_sample_in;
      out_last_ff    <= out_last_in;
      out_clip_ff    <= out_clip_in;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_sample  = out_sample_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_clipped = out_clip_ff;

endmodule
